FILE: rtl/core/vra_pkg.sv
package vra_pkg;

  localparam int MAX_DIM    = 512;
  localparam int VALUE_BITS = 32;

  // Coordinate and effective extent widths follow the largest extent
  localparam int COORD_W  = $clog2(MAX_DIM);
  localparam int ESIZE_W  = $clog2(MAX_DIM + 1);
  localparam int STRIDE_W = 2 * ESIZE_W;

  // Fixed field widths
  localparam int SIZE_W     = 10;
  localparam int MAP_W      = 2;
  localparam int FLIP_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;
  localparam int VOXEL_W    = 32;
  localparam int IDX_W      = 27;

  localparam logic [VOXEL_W-1:0] VAL_MASK =
    (VALUE_BITS >= VOXEL_W) ? {VOXEL_W{1'b1}} : VOXEL_W'((64'd1 << VALUE_BITS) - 64'd1);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z     = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_MAP_X = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_MAP_Y = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_MAP_Z = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_FLIP_MASK  = CFG_IDX_W'(6);

  typedef logic [COORD_W-1:0]  coord_t;
  typedef logic [ESIZE_W-1:0]  esize_t;
  typedef logic [MAP_W-1:0]    map_t;
  typedef logic [STRIDE_W-1:0] stride_t;

  // Live configuration plus derived strides
  typedef struct packed {
    esize_t [2:0] size;
    map_t   [2:0] map;
    logic [FLIP_W-1:0] flip;
    stride_t src_stride_z;
    esize_t  can_stride_y;
    stride_t can_stride_z;
  } cfg_t;

  // Scan stage word
  typedef struct packed {
    logic [VOXEL_W-1:0] value;
    coord_t [2:0] pos;
    coord_t [2:0] cc;
    logic last;
  } scan_t;

  // Zero acts as one, anything above MAX_DIM as MAX_DIM
  function automatic esize_t eff_size(input logic [SIZE_W-1:0] s);
    logic [31:0] s32;
    logic [31:0] r;
    s32 = 32'(s);
    if (s32 == 32'd0) begin
      r = 32'd1;
    end else if (s32 > 32'(MAX_DIM)) begin
      r = 32'(MAX_DIM);
    end else begin
      r = s32;
    end
    return esize_t'(r);
  endfunction

endpackage

FILE: rtl/core/vra_cfg.sv
module vra_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [vra_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [vra_pkg::CFG_DATA_W-1:0] wr_data,
  output vra_pkg::cfg_t                  cfg
);
  import vra_pkg::*;

  esize_t [2:0] size_r;
  map_t   [2:0] map_r;
  logic [FLIP_W-1:0] flip_r;
  stride_t src_stride_z_r, src_stride_z_nxt;
  esize_t  can_stride_y_r;
  stride_t can_stride_z_r, can_stride_z_nxt;
  esize_t [2:0] ce;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= {esize_t'(1), esize_t'(1), esize_t'(1)};
      map_r  <= {map_t'(2), map_t'(1), map_t'(0)};
      flip_r <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_SIZE_X:     size_r[0] <= eff_size(wr_data[SIZE_W-1:0]);
        REG_SIZE_Y:     size_r[1] <= eff_size(wr_data[SIZE_W-1:0]);
        REG_SIZE_Z:     size_r[2] <= eff_size(wr_data[SIZE_W-1:0]);
        REG_AXIS_MAP_X: map_r[0]  <= wr_data[MAP_W-1:0];
        REG_AXIS_MAP_Y: map_r[1]  <= wr_data[MAP_W-1:0];
        REG_AXIS_MAP_Z: map_r[2]  <= wr_data[MAP_W-1:0];
        REG_FLIP_MASK:  flip_r    <= wr_data[FLIP_W-1:0];
        default: ;
      endcase
    end
  end

  // Canonical extents: higher source axis wins, unfed axis has extent 1
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ce[k] = esize_t'(1);
      for (int i = 0; i < 3; i++) begin
        if (map_r[i] == map_t'(k)) ce[k] = size_r[i];
      end
    end
    src_stride_z_nxt = stride_t'(size_r[0]) * stride_t'(size_r[1]);
    can_stride_z_nxt = stride_t'(ce[0]) * stride_t'(ce[1]);
  end

  // Strides are registered from the live size and map registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_stride_z_r <= stride_t'(1);
      can_stride_y_r <= esize_t'(1);
      can_stride_z_r <= stride_t'(1);
    end else begin
      src_stride_z_r <= src_stride_z_nxt;
      can_stride_y_r <= ce[0];
      can_stride_z_r <= can_stride_z_nxt;
    end
  end

  assign cfg.size         = size_r;
  assign cfg.map          = map_r;
  assign cfg.flip         = flip_r;
  assign cfg.src_stride_z = src_stride_z_r;
  assign cfg.can_stride_y = can_stride_y_r;
  assign cfg.can_stride_z = can_stride_z_r;

endmodule

FILE: rtl/core/vra_scan.sv
module vra_scan (
  input  logic                        clk,
  input  logic                        rst_n,
  input  vra_pkg::cfg_t               cfg,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [vra_pkg::VOXEL_W-1:0] in_voxel_value,
  output logic                        s1_valid,
  output vra_pkg::scan_t              s1_word,
  input  logic                        s1_take
);
  import vra_pkg::*;

  coord_t [2:0] cnt_r;
  coord_t [2:0] cnt_nxt;
  coord_t [2:0] lim;
  coord_t [2:0] pos;
  coord_t [2:0] cc;
  logic   [2:0] at_end;
  logic         s1_valid_r;
  scan_t        s1_r;
  scan_t        s1_nxt;
  logic         accept;

  assign in_ready = !s1_valid_r || s1_take;
  assign accept   = in_valid && in_ready;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lim[i]    = coord_t'(cfg.size[i] - esize_t'(1));
      pos[i]    = (cnt_r[i] > lim[i]) ? lim[i] : cnt_r[i];
      at_end[i] = (pos[i] == lim[i]);
    end
    // higher source axis overrides on a shared canonical axis
    for (int k = 0; k < 3; k++) begin
      cc[k] = '0;
      for (int i = 0; i < 3; i++) begin
        if (cfg.map[i] == map_t'(k)) cc[k] = cfg.flip[i] ? (lim[i] - pos[i]) : pos[i];
      end
    end
    cnt_nxt = cnt_r;
    if (at_end[0]) begin
      cnt_nxt[0] = '0;
      if (at_end[1]) begin
        cnt_nxt[1] = '0;
        cnt_nxt[2] = at_end[2] ? '0 : pos[2] + coord_t'(1);
      end else begin
        cnt_nxt[1] = pos[1] + coord_t'(1);
      end
    end else begin
      cnt_nxt[0] = pos[0] + coord_t'(1);
    end
    s1_nxt.value = in_voxel_value & VAL_MASK;
    s1_nxt.pos   = pos;
    s1_nxt.cc    = cc;
    s1_nxt.last  = &at_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (accept) cnt_r <= cnt_nxt;
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_take) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) s1_r <= s1_nxt;
  end

  assign s1_valid = s1_valid_r;
  assign s1_word  = s1_r;

  a_wrap_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && s1_nxt.last) |=> (cnt_r == '0))
    else $error("counters did not wrap after last voxel");

  a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !at_end[0]) |=> (cnt_r[0] == $past(pos[0]) + coord_t'(1)))
    else $error("column counter did not step");

  a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(cnt_r))
    else $error("counters moved without an accepted word");

endmodule

FILE: rtl/core/vra_addr.sv
module vra_addr (
  input  logic                        clk,
  input  logic                        rst_n,
  input  vra_pkg::cfg_t               cfg,
  input  logic                        s1_valid,
  input  vra_pkg::scan_t              s1_word,
  output logic                        s1_take,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [vra_pkg::VOXEL_W-1:0] out_voxel_out,
  output logic [vra_pkg::IDX_W-1:0]   out_source_index,
  output logic [vra_pkg::IDX_W-1:0]   out_canonical_index,
  output logic                        out_last_voxel
);
  import vra_pkg::*;

  logic [COORD_W+STRIDE_W-1:0] p_src_z, p_can_z;
  logic [COORD_W+ESIZE_W-1:0]  p_src_y, p_can_y;
  logic [IDX_W-1:0]            src_nxt, can_nxt;
  logic                        valid_r;
  logic [VOXEL_W-1:0]          value_r;
  logic [IDX_W-1:0]            src_r, can_r;
  logic                        last_r;
  logic                        load;

  assign s1_take = !valid_r || out_ready;
  assign load    = s1_valid && s1_take;

  always_comb begin
    p_src_z = s1_word.pos[2] * cfg.src_stride_z;
    p_src_y = s1_word.pos[1] * cfg.size[0];
    p_can_z = s1_word.cc[2] * cfg.can_stride_z;
    p_can_y = s1_word.cc[1] * cfg.can_stride_y;
    src_nxt = IDX_W'(p_src_z) + IDX_W'(p_src_y) + IDX_W'(s1_word.pos[0]);
    can_nxt = IDX_W'(p_can_z) + IDX_W'(p_can_y) + IDX_W'(s1_word.cc[0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      value_r <= s1_word.value;
      src_r   <= src_nxt;
      can_r   <= can_nxt;
      last_r  <= s1_word.last;
    end
  end

  assign out_valid           = valid_r;
  assign out_voxel_out       = value_r;
  assign out_source_index    = src_r;
  assign out_canonical_index = can_r;
  assign out_last_voxel      = last_r;

endmodule

FILE: rtl/core/voxel_reorient_address_gen.sv
// Voxel reorientation address generator. Voxel words stream in source scan
// order (x fastest, then y, then z) and each one comes out with its source
// linear address and its canonical linear address, after the configured axis
// permutation and per-axis flips. One word is accepted per cycle, sustained
// while out_ready stays high; a word's result passes the two-stage pipeline
// (scan register, then the stride multiply and result register), and the
// pipeline stalls while the receiver holds out_ready low.
// Configuration writes are taken in any cycle (cfg_ready is tied high) but
// should only be made while the block is idle; derived strides are registered
// from the written values. Writes do not restart the scan counters, and an
// unused register index is ignored.
module voxel_reorient_address_gen (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [vra_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vra_pkg::CFG_DATA_W-1:0] cfg_data,
  // voxel input word
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [vra_pkg::VOXEL_W-1:0]    in_voxel_value,
  // result word
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [vra_pkg::VOXEL_W-1:0]    out_voxel_out,
  output logic [vra_pkg::IDX_W-1:0]      out_source_index,
  output logic [vra_pkg::IDX_W-1:0]      out_canonical_index,
  output logic                           out_last_voxel
);
  import vra_pkg::*;

  cfg_t  cfg;
  logic  s1_valid;
  scan_t s1_word;
  logic  s1_take;

  // register file never stalls
  assign cfg_ready = 1'b1;

  vra_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // counters, clamp, flips and permutation; stage one register
  vra_scan u_scan (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_voxel_value (in_voxel_value),
    .s1_valid       (s1_valid),
    .s1_word        (s1_word),
    .s1_take        (s1_take)
  );

  // stride products and the result register
  vra_addr u_addr (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg),
    .s1_valid            (s1_valid),
    .s1_word             (s1_word),
    .s1_take             (s1_take),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_voxel_out       (out_voxel_out),
    .out_source_index    (out_source_index),
    .out_canonical_index (out_canonical_index),
    .out_last_voxel      (out_last_voxel)
  );

endmodule

FILE: dv/tb_voxel_reorient_address_gen.sv
`timescale 1ns / 100ps

module tb_voxel_reorient_address_gen;
  import vra_pkg::*;

  // Run shape
  localparam int RANDOM_WORDS = 1150;
  localparam int HOLD_CYCLES  = 200;     // long receiver hold-off, once
  localparam int HOLD_AFTER   = 300;     // random words queued before the hold-off
  localparam int CYCLE_LIMIT  = 300000;  // far above the slowest legal run
  localparam int DRAIN_CYCLES = 8;       // two-stage pipe plus margin

  // Index past the register file, written to check it is ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(7);

  // One expected result word
  typedef struct packed {
    logic [VOXEL_W-1:0] voxel;
    logic [IDX_W-1:0]   src_addr;
    logic [IDX_W-1:0]   can_addr;
    logic               last;
  } addr_result_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  logic                  in_valid       = 1'b0;
  logic                  in_ready;
  logic [VOXEL_W-1:0]    in_voxel_value = '0;

  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [VOXEL_W-1:0]    out_voxel_out;
  logic [IDX_W-1:0]      out_source_index;
  logic [IDX_W-1:0]      out_canonical_index;
  logic                  out_last_voxel;

  voxel_reorient_address_gen u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_voxel_value      (in_voxel_value),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_voxel_out       (out_voxel_out),
    .out_source_index    (out_source_index),
    .out_canonical_index (out_canonical_index),
    .out_last_voxel      (out_last_voxel)
  );

  always #5 clk = ~clk;

  // Shadow of the register file and of the scan counters (x, y, z)
  logic [SIZE_W-1:0] size_q [3];
  map_t              map_q  [3];
  logic [FLIP_W-1:0] flip_q;
  coord_t            scan_pos [3];

  logic [VOXEL_W-1:0] pending_voxels [$];   // words waiting for the driver
  addr_result_t       expected_addrs [$];   // results owed by the block

  int  n_queued  = 0;
  int  n_results = 0;
  int  err_count = 0;
  int  cycles    = 0;

  // Handshake flags from the last rising edge, read by the drivers at the falling edge
  bit  in_acc  = 1'b0;
  bit  out_acc = 1'b0;

  bit  hold_arm = 1'b0;
  bit  hold_off = 1'b0;

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  // Address pair for the next voxel in scan order; advances the scan counters
  function automatic addr_result_t next_address(input logic [VOXEL_W-1:0] v);
    int unsigned     ext [3];
    int unsigned     pos [3];
    int unsigned     cext [3];
    int unsigned     ccrd [3];
    bit              at_end [3];
    int unsigned     k;
    longint unsigned src;
    longint unsigned can;
    addr_result_t    r;

    for (int i = 0; i < 3; i++) begin
      // zero acts as one, oversize saturates at the largest extent
      if (size_q[i] == '0) begin
        ext[i] = 1;
      end else if (int'(size_q[i]) > MAX_DIM) begin
        ext[i] = MAX_DIM;
      end else begin
        ext[i] = size_q[i];
      end
      // a counter left beyond a shrunk extent sits on the last position
      pos[i] = scan_pos[i];
      if (pos[i] > ext[i] - 1) pos[i] = ext[i] - 1;
      at_end[i] = (pos[i] == ext[i] - 1);
      cext[i] = 1;
      ccrd[i] = 0;
    end

    // later source axes overwrite earlier ones on a shared canonical axis
    for (int i = 0; i < 3; i++) begin
      k = map_q[i];
      if (k < 3) begin
        cext[k] = ext[i];
        ccrd[k] = flip_q[i] ? (ext[i] - 1 - pos[i]) : pos[i];
      end
    end

    src = longint'(pos[2]) * ext[0] * ext[1] + longint'(pos[1]) * ext[0] + pos[0];
    can = longint'(ccrd[2]) * cext[0] * cext[1] + longint'(ccrd[1]) * cext[0] + ccrd[0];

    r.voxel    = v & VAL_MASK;
    r.src_addr = IDX_W'(src);
    r.can_addr = IDX_W'(can);
    r.last     = at_end[0] && at_end[1] && at_end[2];

    if (at_end[0]) begin
      scan_pos[0] = '0;
      if (at_end[1]) begin
        scan_pos[1] = '0;
        scan_pos[2] = at_end[2] ? coord_t'(0) : coord_t'(pos[2] + 1);
      end else begin
        scan_pos[1] = coord_t'(pos[1] + 1);
      end
    end else begin
      scan_pos[0] = coord_t'(pos[0] + 1);
    end
    return r;
  endfunction

  // Monitor: every handshake is sampled at the rising edge
  always @(posedge clk) begin
    addr_result_t want;
    in_acc  = 1'b0;
    out_acc = 1'b0;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SIZE_X:     size_q[0] = cfg_data;
          REG_SIZE_Y:     size_q[1] = cfg_data;
          REG_SIZE_Z:     size_q[2] = cfg_data;
          REG_AXIS_MAP_X: map_q[0]  = cfg_data[MAP_W-1:0];
          REG_AXIS_MAP_Y: map_q[1]  = cfg_data[MAP_W-1:0];
          REG_AXIS_MAP_Z: map_q[2]  = cfg_data[MAP_W-1:0];
          REG_FLIP_MASK:  flip_q    = cfg_data[FLIP_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        in_acc = 1'b1;
        expected_addrs.push_back(next_address(in_voxel_value));
      end
      if (out_valid && out_ready) begin
        out_acc = 1'b1;
        if (expected_addrs.size() == 0) begin
          report_error($sformatf("result word %0d with nothing owed", n_results));
        end else begin
          want = expected_addrs.pop_front();
          if (out_voxel_out !== want.voxel)
            report_error($sformatf("word %0d voxel_out: exp %h got %h",
                                   n_results, want.voxel, out_voxel_out));
          if (out_source_index !== want.src_addr)
            report_error($sformatf("word %0d source_index: exp %0d got %0d",
                                   n_results, want.src_addr, out_source_index));
          if (out_canonical_index !== want.can_addr)
            report_error($sformatf("word %0d canonical_index: exp %0d got %0d",
                                   n_results, want.can_addr, out_canonical_index));
          if (out_last_voxel !== want.last)
            report_error($sformatf("word %0d last_voxel: exp %b got %b",
                                   n_results, want.last, out_last_voxel));
        end
        n_results++;
      end
    end
  end

  // Input driver: offers queued words, with a random gap after each one
  int unsigned tx_gap   = 0;
  bit          tx_burst = 1'b0;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_acc) begin
      if (tx_gap != 0) begin
        in_valid <= 1'b0;
        tx_gap--;
      end else if (pending_voxels.size() != 0) begin
        in_valid       <= 1'b1;
        in_voxel_value <= pending_voxels.pop_front();
        if ($urandom_range(0, 47) == 0) tx_burst = !tx_burst;
        tx_gap = tx_burst ? 0 : $urandom_range(0, 7);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: stalls a random number of cycles after each word
  int unsigned rx_stall = 0;
  bit          rx_burst = 1'b0;

  always @(negedge clk) begin
    if (out_acc) begin
      if ($urandom_range(0, 47) == 0) rx_burst = !rx_burst;
      rx_stall = rx_burst ? 0 : $urandom_range(0, 7);
    end
    if (rx_stall != 0) begin
      out_ready <= 1'b0;
      rx_stall--;
    end else begin
      out_ready <= !hold_off;
    end
  end

  // One long hold-off so the pipe fills and back-pressures the input
  initial begin
    int held;
    wait (hold_arm);
    @(posedge clk);
    hold_off = 1'b1;
    for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
    hold_off = 1'b0;
  end

  // Watchdog
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("** voxel_reorient_address_gen: FAILED **");
    $finish;
  end

  task automatic queue_voxel(input logic [VOXEL_W-1:0] v);
    pending_voxels.push_back(v);
    n_queued++;
  endtask

  // Register write; valid is left high for a following write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
  endtask

  // Waits for the block to drain, then loads a full setting
  task automatic set_volume(input logic [CFG_DATA_W-1:0] sx, sy, sz, mx, my, mz, fl,
                            input bit poke_unused);
    while (n_results < n_queued) @(negedge clk);
    repeat (4) @(negedge clk);
    write_reg(REG_SIZE_X, sx);
    write_reg(REG_SIZE_Y, sy);
    write_reg(REG_SIZE_Z, sz);
    write_reg(REG_AXIS_MAP_X, mx);
    write_reg(REG_AXIS_MAP_Y, my);
    write_reg(REG_AXIS_MAP_Z, mz);
    write_reg(REG_FLIP_MASK, fl);
    if (poke_unused) write_reg(REG_UNUSED, CFG_DATA_W'($urandom_range(0, 1023)));
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stimulus
  initial begin
    int          n_random;
    int          cnt;
    int          mode;
    int unsigned vol;
    int unsigned perm [3];
    int unsigned tmp;
    int unsigned j;
    logic [CFG_DATA_W-1:0] sz [3];
    logic [CFG_DATA_W-1:0] mp [3];
    logic [CFG_DATA_W-1:0] fl;

    for (int i = 0; i < 3; i++) begin
      size_q[i]   = SIZE_W'(1);
      map_q[i]    = map_t'(i);
      scan_pos[i] = '0;
    end
    flip_q = '0;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset setting: 1x1x1, so every word is the last of its volume
    queue_voxel(32'h0000_0000);
    queue_voxel(32'hFFFF_FFFF);

    // Full 2x2x2 volume, all axes reversed, unused index poked
    set_volume(10'd2, 10'd2, 10'd2, 10'd0, 10'd1, 10'd2, 10'd7, 1'b1);
    queue_voxel(32'h5555_5555);
    queue_voxel(32'hAAAA_AAAA);
    queue_voxel(32'h8000_0000);
    queue_voxel(32'h0000_0001);
    queue_voxel(32'h7FFF_FFFF);
    queue_voxel(32'hFFFF_FFFE);
    queue_voxel(32'h1234_5678);
    queue_voxel(32'hDEAD_BEEF);

    // Zero and oversize extents; x feeds nothing, y and z share axis 0 (z wins)
    set_volume(10'd0, 10'd1023, 10'd3, 10'd3, 10'd0, 10'd0, 10'h3FA, 1'b0);
    for (int i = 0; i < 6; i++) queue_voxel($urandom());

    // Extents shrink under a running row counter; reversed permutation
    set_volume(10'd3, 10'd1, 10'd2, 10'h3FE, 10'd1, 10'd0, 10'd5, 1'b0);
    for (int i = 0; i < 6; i++) queue_voxel($urandom());

    // Largest exact extent and oversize extents, rotated axes
    set_volume(10'd512, 10'd600, 10'd513, 10'd1, 10'd2, 10'd0, 10'd0, 1'b0);
    for (int i = 0; i < 3; i++) queue_voxel($urandom());

    n_random = 0;
    while (n_random < RANDOM_WORDS) begin
      mode = $urandom_range(0, 9);
      for (int i = 0; i < 3; i++) perm[i] = i;
      for (int i = 2; i > 0; i--) begin
        j = $urandom_range(0, i);
        tmp = perm[i]; perm[i] = perm[j]; perm[j] = tmp;
      end
      for (int i = 0; i < 3; i++) begin
        sz[i] = CFG_DATA_W'($urandom_range(1, 6));
        mp[i] = CFG_DATA_W'(perm[i]);
      end
      if (mode == 7) begin
        // one axis at an edge of the extent range
        case ($urandom_range(0, 5))
          0: sz[$urandom_range(0, 2)] = 10'd0;
          1: sz[$urandom_range(0, 2)] = 10'd1;
          2: sz[$urandom_range(0, 2)] = 10'd511;
          3: sz[$urandom_range(0, 2)] = 10'd512;
          4: sz[$urandom_range(0, 2)] = 10'd513;
          default: sz[$urandom_range(0, 2)] = 10'd1023;
        endcase
      end else if (mode == 8) begin
        // arbitrary maps: unused, duplicated or missing canonical axes
        for (int i = 0; i < 3; i++) begin
          sz[i] = CFG_DATA_W'($urandom_range(0, 8));
          mp[i] = CFG_DATA_W'($urandom_range(0, 3));
        end
      end else if (mode == 9) begin
        for (int i = 0; i < 3; i++) sz[i] = CFG_DATA_W'($urandom_range(0, 1023));
      end
      // junk above the live bits must be dropped
      for (int i = 0; i < 3; i++) mp[i] = mp[i] | CFG_DATA_W'($urandom_range(0, 255) << MAP_W);
      fl = CFG_DATA_W'($urandom_range(0, 7)) | CFG_DATA_W'($urandom_range(0, 127) << FLIP_W);

      set_volume(sz[0], sz[1], sz[2], mp[0], mp[1], mp[2], fl, $urandom_range(0, 7) == 0);

      if (mode <= 6) begin
        // whole volumes so the wrap and the last-voxel mark are exercised
        vol = sz[0] * sz[1] * sz[2];
        cnt = vol * $urandom_range(1, 3);
        if (cnt > 160) cnt = $urandom_range(40, 160);
      end else begin
        cnt = $urandom_range(20, 80);
      end
      if (!hold_arm && n_random >= HOLD_AFTER) cnt = 150;

      for (int i = 0; i < cnt; i++) begin
        case ($urandom_range(0, 15))
          0:       queue_voxel(32'hFFFF_FFFF);
          1:       queue_voxel(32'h0000_0000);
          default: queue_voxel($urandom());
        endcase
      end
      if (!hold_arm && n_random >= HOLD_AFTER) hold_arm = 1'b1;
      n_random += cnt;
    end

    while (n_results < n_queued) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (expected_addrs.size() != 0)
      report_error($sformatf("%0d result words never arrived", expected_addrs.size()));

    if (err_count == 0) begin
      $display("** voxel_reorient_address_gen: PASSED **");
    end else begin
      $display("** voxel_reorient_address_gen: FAILED **");
    end
    $finish;
  end

endmodule
